// ----- rtl/core/lkvc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

   // Field widths fixed by the interface.
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   // Defaults.
   localparam int ENTRIES_DEFAULT = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request kinds carried on req_tuser.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Value returned by a get that misses.
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   // One stored pair together with its occupancy flag.
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } entry_type;

   // Per-cell control issued by the sequencer.
   typedef struct packed {
      logic lookup_en;
      logic shift_en;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/lkvc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One position of the recency list. Position 0 is the most recent entry.
// On a shift the cell takes the entry of its left neighbor.
module lkvc_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lkvc_pkg::cell_ctrl_type     ctrl,
   input  wire logic [lkvc_pkg::DATA_W-1:0] lookup_key,
   input  wire lkvc_pkg::entry_type         prev_entry,
   output lkvc_pkg::entry_type              entry,
   output logic                             match
);
   import lkvc_pkg::*;

   logic              valid_ff;
   logic [DATA_W-1:0] key_ff;
   logic [DATA_W-1:0] value_ff;
   logic              match_ff;

   // Occupancy and match flag are control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctrl.shift_en) begin
            valid_ff <= prev_entry.valid;
         end
         if (ctrl.lookup_en) begin
            match_ff <= valid_ff && (key_ff == lookup_key);
         end
      end
   end

   // Stored pair moves with the list.
   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         key_ff   <= prev_entry.key;
         value_ff <= prev_entry.value;
      end
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.value = value_ff;
   assign match       = match_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lkvc_select.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Reduces the one-hot match flags of the cells to a hit flag, the matching
// value and the matching position.
module lkvc_select #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int IDX_W   = 1
) (
   input  wire logic [ENTRIES-1:0]          match_vec,
   input  wire lkvc_pkg::entry_type         cell_entry [ENTRIES],
   output logic                             hit,
   output logic [lkvc_pkg::DATA_W-1:0]      hit_value,
   output logic [IDX_W-1:0]                 hit_pos
);
   import lkvc_pkg::*;

   // Keys are unique among valid cells, so an OR of masked fields selects.
   always_comb begin
      hit_value = '0;
      hit_pos   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_vec[i]) begin
            hit_value = hit_value | cell_entry[i].value;
            hit_pos   = hit_pos | IDX_W'(i);
         end
      end
   end

   assign hit = |match_vec;

endmodule

`default_nettype wire

// ----- rtl/core/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Fields (lowest bit first)
// req_*     in         tdata: key[31:0], put_value[63:32]; tuser: opcode
// rsp_*     out        tdata: read_value[31:0]; tuser: hit
// csr_*     in         wdata: capacity[4:0]
//
// Each transaction steps through accept, key compare in all cells, match
// reduction and the list shift, which on a get loads the result register.
// The list is a row of ENTRIES cells kept in recency order; a hit or an
// insert moves the entry to the head while the cells in front of it shift
// back by one. Reset empties the list at once; no clearing pass is needed.
// A get waits in the shift step while the previous result is still not
// taken; a put never waits on rsp_tready.
module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [2*lkvc_pkg::DATA_W-1:0] req_tdata,  // key, put_value
   input  wire logic                          req_tuser,  // opcode
   // Result channel.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [lkvc_pkg::DATA_W-1:0]        rsp_tdata,  // read_value
   output logic                               rsp_tuser,  // hit
   // Capacity register.
   input  wire logic                          csr_we,
   input  wire logic [lkvc_pkg::CAP_W-1:0]    csr_wdata
);
   import lkvc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_RESOLVE,
      ST_UPDATE
   } state_type;

   state_type         state_ff;
   logic              op_ff;
   logic [DATA_W-1:0] key_ff;
   logic [DATA_W-1:0] put_value_ff;
   logic              hit_ff;
   logic [DATA_W-1:0] hit_value_ff;
   logic [IDX_W-1:0]  hit_pos_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CAP_W-1:0]  capacity_ff;
   logic              rsp_tvalid_ff;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   entry_type         head_entry;
   entry_type         cell_entry [ENTRIES];
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES-1:0] shift_vec;

   logic              sel_hit;
   logic [DATA_W-1:0] sel_value;
   logic [IDX_W-1:0]  sel_pos;

   logic              out_busy;
   logic              proceed;
   logic              cap_zero;
   logic              has_room;
   logic              do_shift;
   logic              do_insert;
   logic [IDX_W-1:0]  target;
   logic [CNT_W-1:0]  count_last;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   // Decide how the list moves for the transaction in hand.
   assign out_busy   = rsp_tvalid_ff && !rsp_tready;
   assign proceed    = (state_ff == ST_UPDATE) && !((op_ff == OP_GET) && out_busy);
   assign cap_zero   = (capacity_ff == '0);
   assign has_room   = (count_ff != CNT_W'(ENTRIES)) &&
                       (CMP_W'(count_ff) < CMP_W'(capacity_ff));
   assign count_last = count_ff - CNT_W'(1);

   always_comb begin
      do_shift  = 1'b0;
      do_insert = 1'b0;
      target    = hit_pos_ff;
      priority if (op_ff == OP_GET) begin
         do_shift = hit_ff;
      end else if (cap_zero) begin
         do_shift = 1'b0;
      end else if (hit_ff) begin
         do_shift = 1'b1;
      end else if (has_room) begin
         do_shift  = 1'b1;
         do_insert = 1'b1;
         target    = count_ff[IDX_W-1:0];
      end else begin
         // Full: the least recent entry sits at the last occupied position.
         do_shift = 1'b1;
         target   = count_last[IDX_W-1:0];
      end
   end

   // The head cell takes the request key with its new or found value.
   assign head_entry.valid = 1'b1;
   assign head_entry.key   = key_ff;
   assign head_entry.value = (op_ff == OP_PUT) ? put_value_ff : hit_value_ff;

   // Row of cells.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     prev;

      assign shift_vec[i]   = proceed && do_shift && (IDX_W'(i) <= target);
      assign ctrl.shift_en  = shift_vec[i];
      assign ctrl.lookup_en = (state_ff == ST_LOOKUP);

      if (i == 0) begin : g_head
         assign prev = head_entry;
      end else begin : g_body
         assign prev = cell_entry[i-1];
      end

      lkvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .lookup_key (key_ff),
         .prev_entry (prev),
         .entry      (cell_entry[i]),
         .match      (match_vec[i])
      );

      assign valid_vec[i] = cell_entry[i].valid;
   end

   lkvc_select #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_select (
      .match_vec  (match_vec),
      .cell_entry (cell_entry),
      .hit        (sel_hit),
      .hit_value  (sel_value),
      .hit_pos    (sel_pos)
   );

   // Request payload and match results.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_tvalid) begin
         op_ff        <= req_tuser;
         key_ff       <= req_tdata[DATA_W-1:0];
         put_value_ff <= req_tdata[2*DATA_W-1:DATA_W];
      end
      if (state_ff == ST_RESOLVE) begin
         hit_value_ff <= sel_value;
         hit_pos_ff   <= sel_pos;
      end
   end

   // Sequencer with the entry count and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hit_ff        <= 1'b0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_hit_ff    <= 1'b0;
         rsp_value_ff  <= '0;
      end else begin
         // A completed get loads the result; a taken result empties it.
         if (proceed && (op_ff == OP_GET)) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_hit_ff    <= hit_ff;
            rsp_value_ff  <= hit_ff ? hit_value_ff : MISS_VALUE;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_RESOLVE;
            end
            ST_RESOLVE: begin
               hit_ff   <= sel_hit;
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (proceed) begin
                  if (do_insert) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

   // The occupied cells and the entry count agree.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count differs from occupied cells");

   // A key is held in at most one cell.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key matched in more than one cell");

   // A new result only follows the shift step of a get.
   a_result_from_get: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(proceed && (op_ff == OP_GET)))
      else $error("result raised without a completed get");

   // The list never shifts while a request is being accepted or compared.
   a_shift_only_in_update: assert property (@(posedge clock) disable iff (reset)
      (shift_vec != '0) |-> (state_ff == ST_UPDATE))
      else $error("cells shifted outside the update step");

endmodule

`default_nettype wire
